/* hdl/tlpmg_pkg.sv */
package tlpmg_pkg;

    // Field widths
    localparam int LoadW     = 16;
    localparam int TccW      = 8;
    localparam int OffsetW   = 7;
    localparam int TempW     = 7;
    localparam int ModeW     = 2;
    localparam int CountW    = 4;
    localparam int CoolW     = 8;
    localparam int EppW      = 8;
    localparam int CfgIndexW = 3;
    localparam int CfgDataW  = 16;

    // Power mode codes
    localparam logic [ModeW-1:0] MODE_LOW   = 2'd0;
    localparam logic [ModeW-1:0] MODE_HEAVY = 2'd1;
    localparam logic [ModeW-1:0] MODE_COOL  = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIndexW-1:0] CFG_TEMP_HIGH      = 3'd0;
    localparam logic [CfgIndexW-1:0] CFG_TEMP_RECOVERY  = 3'd1;
    localparam logic [CfgIndexW-1:0] CFG_RECOVERY_TICKS = 3'd2;
    localparam logic [CfgIndexW-1:0] CFG_LOAD_THRESHOLD = 3'd3;
    localparam logic [CfgIndexW-1:0] CFG_COOLDOWN_TICKS = 3'd4;
    localparam logic [CfgIndexW-1:0] CFG_EPP_LOW        = 3'd5;
    localparam logic [CfgIndexW-1:0] CFG_EPP_HEAVY      = 3'd6;

    // Configuration reset values
    localparam logic [TempW-1:0]  RST_TEMP_HIGH      = 7'd85;
    localparam logic [TempW-1:0]  RST_TEMP_RECOVERY  = 7'd75;
    localparam logic [CountW-1:0] RST_RECOVERY_TICKS = 4'd3;
    localparam logic [LoadW-1:0]  RST_LOAD_THRESHOLD = 16'd1000;
    localparam logic [CoolW-1:0]  RST_COOLDOWN_TICKS = 8'd5;
    localparam logic [EppW-1:0]   RST_EPP_LOW        = 8'd208;
    localparam logic [EppW-1:0]   RST_EPP_HEAVY      = 8'd128;

    // Activation target sanity window and fallback
    localparam logic [TccW-1:0] TCC_MIN      = 8'd70;
    localparam logic [TccW-1:0] TCC_MAX      = 8'd110;
    localparam logic [TccW-1:0] TCC_FALLBACK = 8'd100;
    localparam logic [CoolW-1:0] COOL_SAT    = 8'hFF;

    // Captured input transaction
    typedef struct packed {
        logic [LoadW-1:0]   load_factor;
        logic [TccW-1:0]    tcc_target;
        logic [OffsetW-1:0] readout_offset;
        logic               reading_valid;
    } tick_t;

    // One result transaction
    typedef struct packed {
        logic [TempW-1:0]  temperature;
        logic [ModeW-1:0]  mode;
        logic              throttled;
        logic [CountW-1:0] recovery_count;
        logic              profile_apply;
        logic              profile_heavy;
        logic [EppW-1:0]   epp_value;
        logic              fan_kick;
    } result_t;

    // Temperature from raw thermal fields; 0 when the reading is unusable
    function automatic logic [TempW-1:0] derive_temp(
        input logic [TccW-1:0]    tcc,
        input logic [OffsetW-1:0] off,
        input logic               valid
    );
        logic [TccW-1:0] target;
        logic [TccW-1:0] diff;
        begin
            target = ((tcc < TCC_MIN) || (tcc > TCC_MAX)) ? TCC_FALLBACK : tcc;
            diff   = target - {1'b0, off};
            if (!valid || ({1'b0, off} > target))
                derive_temp = '0;
            else
                derive_temp = diff[TempW-1:0];
        end
    endfunction

endpackage

/* hdl/thermal_load_power_mode_governor.sv */
// Channel | Handshake            | Payload
// --------+----------------------+---------------------------------------------------
// in      | in_valid / in_stall  | load_factor, tcc_target, readout_offset,
//         |                      | reading_valid
// out     | out_valid / out_stall| temperature, mode, throttled, recovery_count,
//         |                      | profile_apply, profile_heavy, epp_value, fan_kick
// cfg     | cfg_we               | cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low; a tick passes through
// the input register, then the result register, from input accept to result valid.
// Governor state is updated when the captured tick moves into the result register.
// in_stall rises only when the input register is full and the result register
// is held by out_stall. Reset (rst_n, async) restores config and state defaults.
module thermal_load_power_mode_governor (
    input  logic                           clk,
    input  logic                           rst_n,
    // input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [tlpmg_pkg::LoadW-1:0]    load_factor,
    input  logic [tlpmg_pkg::TccW-1:0]     tcc_target,
    input  logic [tlpmg_pkg::OffsetW-1:0]  readout_offset,
    input  logic                           reading_valid,
    // output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tlpmg_pkg::TempW-1:0]    temperature,
    output logic [tlpmg_pkg::ModeW-1:0]    mode,
    output logic                           throttled,
    output logic [tlpmg_pkg::CountW-1:0]   recovery_count,
    output logic                           profile_apply,
    output logic                           profile_heavy,
    output logic [tlpmg_pkg::EppW-1:0]     epp_value,
    output logic                           fan_kick,
    // configuration
    input  logic                           cfg_we,
    input  logic [tlpmg_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [tlpmg_pkg::CfgDataW-1:0] cfg_data
);
    import tlpmg_pkg::*;

    // Configuration registers
    logic [TempW-1:0]  temp_high_reg;
    logic [TempW-1:0]  temp_recovery_reg;
    logic [CountW-1:0] recovery_ticks_reg;
    logic [LoadW-1:0]  load_threshold_reg;
    logic [CoolW-1:0]  cooldown_ticks_reg;
    logic [EppW-1:0]   epp_low_reg;
    logic [EppW-1:0]   epp_heavy_reg;

    // Governor state
    logic [ModeW-1:0]  power_mode_reg,      power_mode_next;
    logic              clamp_active_reg,    clamp_active_next;
    logic [CountW-1:0] cool_tick_count_reg, cool_tick_count_next;
    logic [CoolW-1:0]  cooldown_count_reg,  cooldown_count_next;

    // Pipeline registers
    logic    tick_valid_reg;
    tick_t   tick_reg;
    logic    res_valid_reg;
    result_t res_reg, res_next;

    logic advance;
    logic in_accept;

    // Result register frees when empty or being taken
    assign advance   = !res_valid_reg || !out_stall;
    assign in_stall  = tick_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_high_reg      <= RST_TEMP_HIGH;
            temp_recovery_reg  <= RST_TEMP_RECOVERY;
            recovery_ticks_reg <= RST_RECOVERY_TICKS;
            load_threshold_reg <= RST_LOAD_THRESHOLD;
            cooldown_ticks_reg <= RST_COOLDOWN_TICKS;
            epp_low_reg        <= RST_EPP_LOW;
            epp_heavy_reg      <= RST_EPP_HEAVY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEMP_HIGH:      temp_high_reg      <= cfg_data[TempW-1:0];
                CFG_TEMP_RECOVERY:  temp_recovery_reg  <= cfg_data[TempW-1:0];
                CFG_RECOVERY_TICKS: recovery_ticks_reg <= cfg_data[CountW-1:0];
                CFG_LOAD_THRESHOLD: load_threshold_reg <= cfg_data[LoadW-1:0];
                CFG_COOLDOWN_TICKS: cooldown_ticks_reg <= cfg_data[CoolW-1:0];
                CFG_EPP_LOW:        epp_low_reg        <= cfg_data[EppW-1:0];
                CFG_EPP_HEAVY:      epp_heavy_reg      <= cfg_data[EppW-1:0];
                default: ;
            endcase
        end
    end

    // Tick evaluation: clamp first, then the load machine
    always_comb
    begin
        logic [TempW-1:0]  temp;
        logic              heavy_load;
        logic              apply;
        logic              heavy;
        logic [CountW-1:0] cool_inc;

        temp       = derive_temp(tick_reg.tcc_target, tick_reg.readout_offset,
                                 tick_reg.reading_valid);
        heavy_load = tick_reg.load_factor < load_threshold_reg;
        apply      = 1'b0;
        heavy      = 1'b0;

        power_mode_next      = power_mode_reg;
        clamp_active_next    = clamp_active_reg;
        cool_tick_count_next = cool_tick_count_reg;
        cooldown_count_next  = cooldown_count_reg;

        // Clamp engage
        if ((temp >= temp_high_reg) && !clamp_active_reg)
        begin
            clamp_active_next    = 1'b1;
            cool_tick_count_next = '0;
            power_mode_next      = MODE_LOW;
            apply                = 1'b1;
        end

        // Clamp recovery counting
        cool_inc = cool_tick_count_next + 1'b1;
        if (clamp_active_next)
        begin
            if (temp < temp_recovery_reg)
            begin
                if (cool_inc >= recovery_ticks_reg)
                begin
                    clamp_active_next    = 1'b0;
                    cool_tick_count_next = '0;
                end
                else
                begin
                    cool_tick_count_next = cool_inc;
                end
            end
            else
            begin
                cool_tick_count_next = '0;
            end
        end

        // Load machine, only while unclamped
        if (!clamp_active_next)
        begin
            case (power_mode_next)
                MODE_LOW:
                begin
                    if (heavy_load)
                    begin
                        power_mode_next = MODE_HEAVY;
                        apply           = 1'b1;
                        heavy           = 1'b1;
                    end
                end
                MODE_HEAVY:
                begin
                    if (!heavy_load)
                    begin
                        power_mode_next     = MODE_COOL;
                        cooldown_count_next = '0;
                    end
                end
                MODE_COOL:
                begin
                    if (heavy_load)
                    begin
                        power_mode_next     = MODE_HEAVY;
                        cooldown_count_next = '0;
                    end
                    else
                    begin
                        if (cooldown_count_reg != COOL_SAT)
                            cooldown_count_next = cooldown_count_reg + 1'b1;
                        if (cooldown_count_next >= cooldown_ticks_reg)
                        begin
                            power_mode_next = MODE_LOW;
                            apply           = 1'b1;
                            heavy           = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end

        res_next.temperature    = temp;
        res_next.mode           = power_mode_next;
        res_next.throttled      = clamp_active_next;
        res_next.recovery_count = cool_tick_count_next;
        res_next.profile_apply  = apply;
        res_next.profile_heavy  = apply && heavy;
        res_next.epp_value      = apply ? (heavy ? epp_heavy_reg : epp_low_reg) : '0;
        res_next.fan_kick       = apply && heavy;
    end

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_valid_reg <= 1'b0;
        else if (in_accept)
            tick_valid_reg <= 1'b1;
        else if (advance)
            tick_valid_reg <= 1'b0;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            tick_reg.load_factor    <= load_factor;
            tick_reg.tcc_target     <= tcc_target;
            tick_reg.readout_offset <= readout_offset;
            tick_reg.reading_valid  <= reading_valid;
        end
    end

    // Result valid and governor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg       <= 1'b0;
            power_mode_reg      <= MODE_LOW;
            clamp_active_reg    <= 1'b0;
            cool_tick_count_reg <= '0;
            cooldown_count_reg  <= '0;
        end
        else if (advance)
        begin
            res_valid_reg <= tick_valid_reg;
            if (tick_valid_reg)
            begin
                power_mode_reg      <= power_mode_next;
                clamp_active_reg    <= clamp_active_next;
                cool_tick_count_reg <= cool_tick_count_next;
                cooldown_count_reg  <= cooldown_count_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance && tick_valid_reg)
            res_reg <= res_next;
    end

    assign out_valid      = res_valid_reg;
    assign temperature    = res_reg.temperature;
    assign mode           = res_reg.mode;
    assign throttled      = res_reg.throttled;
    assign recovery_count = res_reg.recovery_count;
    assign profile_apply  = res_reg.profile_apply;
    assign profile_heavy  = res_reg.profile_heavy;
    assign epp_value      = res_reg.epp_value;
    assign fan_kick       = res_reg.fan_kick;

endmodule

/* sim/thermal_load_power_mode_governor_tb.sv */
module thermal_load_power_mode_governor_tb;

    import tlpmg_pkg::*;

    localparam int DIRECTED_COUNT = 25;
    localparam int MAX_REPORTS    = 10;
    localparam int IDLE_LIMIT     = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 60;

    // Activation target window used when deriving the temperature
    localparam int TARGET_MIN     = 70;
    localparam int TARGET_MAX     = 110;
    localparam int TARGET_DEFAULT = 100;
    localparam logic [CoolW-1:0] COOLDOWN_CEIL = 8'hFF;

    // Index with no register behind it; writes must be ignored
    localparam logic [CfgIndexW-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        tick_t   tick;
        logic    has_want;
        result_t want;
    } stim_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_style_t;

    // DUT signals
    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic [LoadW-1:0]     load_factor    = '0;
    logic [TccW-1:0]      tcc_target     = '0;
    logic [OffsetW-1:0]   readout_offset = '0;
    logic                 reading_valid  = 1'b0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic [TempW-1:0]     temperature;
    logic [ModeW-1:0]     mode;
    logic                 throttled;
    logic [CountW-1:0]    recovery_count;
    logic                 profile_apply;
    logic                 profile_heavy;
    logic [EppW-1:0]      epp_value;
    logic                 fan_kick;
    logic                 cfg_we         = 1'b0;
    logic [CfgIndexW-1:0] cfg_index      = '0;
    logic [CfgDataW-1:0]  cfg_data       = '0;

    // Governor copy: settings
    logic [TempW-1:0]  lim_hot      = RST_TEMP_HIGH;
    logic [TempW-1:0]  lim_cool     = RST_TEMP_RECOVERY;
    logic [CountW-1:0] lim_recover  = RST_RECOVERY_TICKS;
    logic [LoadW-1:0]  lim_load     = RST_LOAD_THRESHOLD;
    logic [CoolW-1:0]  lim_cooldown = RST_COOLDOWN_TICKS;
    logic [EppW-1:0]   epp_lo       = RST_EPP_LOW;
    logic [EppW-1:0]   epp_hv       = RST_EPP_HEAVY;

    // Governor copy: state
    logic [ModeW-1:0]  gov_mode = MODE_LOW;
    logic              clamp_on = 1'b0;
    logic [CountW-1:0] cool_cnt = '0;
    logic [CoolW-1:0]  cd_cnt   = '0;

    stim_t   ticks_to_send[$];
    result_t pending_results[$];
    stim_t   directed_rows[DIRECTED_COUNT];

    int bad_results  = 0;
    int idle_cycles  = 0;
    bit hold_pending = 1'b0;
    bit run_hot      = 1'b0;
    bit run_heavy    = 1'b0;

    thermal_load_power_mode_governor i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .load_factor    (load_factor),
        .tcc_target     (tcc_target),
        .readout_offset (readout_offset),
        .reading_valid  (reading_valid),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .temperature    (temperature),
        .mode           (mode),
        .throttled      (throttled),
        .recovery_count (recovery_count),
        .profile_apply  (profile_apply),
        .profile_heavy  (profile_heavy),
        .epp_value      (epp_value),
        .fan_kick       (fan_kick),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One governor tick: updates the state copy and returns the result
    function automatic result_t govern_tick(input tick_t t);
        int      tgt;
        int      deg;
        logic    heavy_load;
        logic    applied;
        logic    to_heavy;
        result_t r;
        begin
            tgt = t.tcc_target;
            if (tgt < TARGET_MIN || tgt > TARGET_MAX)
                tgt = TARGET_DEFAULT;
            if (!t.reading_valid || int'(t.readout_offset) > tgt)
                deg = 0;
            else
                deg = tgt - int'(t.readout_offset);

            applied    = 1'b0;
            to_heavy   = 1'b0;
            heavy_load = t.load_factor < lim_load;

            // hot tick engages the clamp and forces the low profile
            if (deg >= int'(lim_hot) && !clamp_on)
            begin
                clamp_on = 1'b1;
                cool_cnt = '0;
                gov_mode = MODE_LOW;
                applied  = 1'b1;
                to_heavy = 1'b0;
            end

            // recovery counting while clamped
            if (clamp_on)
            begin
                if (deg < int'(lim_cool))
                begin
                    cool_cnt = cool_cnt + 1'b1;
                    if (cool_cnt >= lim_recover)
                    begin
                        clamp_on = 1'b0;
                        cool_cnt = '0;
                    end
                end
                else
                begin
                    cool_cnt = '0;
                end
            end

            // load machine runs only when unclamped
            if (!clamp_on)
            begin
                case (gov_mode)
                    MODE_LOW:
                    begin
                        if (heavy_load)
                        begin
                            gov_mode = MODE_HEAVY;
                            applied  = 1'b1;
                            to_heavy = 1'b1;
                        end
                    end
                    MODE_HEAVY:
                    begin
                        if (!heavy_load)
                        begin
                            gov_mode = MODE_COOL;
                            cd_cnt   = '0;
                        end
                    end
                    MODE_COOL:
                    begin
                        if (heavy_load)
                        begin
                            gov_mode = MODE_HEAVY;
                            cd_cnt   = '0;
                        end
                        else
                        begin
                            if (cd_cnt != COOLDOWN_CEIL)
                                cd_cnt = cd_cnt + 1'b1;
                            if (cd_cnt >= lim_cooldown)
                            begin
                                gov_mode = MODE_LOW;
                                applied  = 1'b1;
                                to_heavy = 1'b0;
                            end
                        end
                    end
                    default: ;
                endcase
            end

            r.temperature    = deg[TempW-1:0];
            r.mode           = gov_mode;
            r.throttled      = clamp_on;
            r.recovery_count = cool_cnt;
            r.profile_apply  = applied;
            r.profile_heavy  = applied & to_heavy;
            r.epp_value      = applied ? (to_heavy ? epp_hv : epp_lo) : '0;
            r.fan_kick       = applied & to_heavy;
            return r;
        end
    endfunction

    function automatic string describe(input result_t r);
        return $sformatf({"temp=%0d mode=%0d throttled=%0b recov=%0d ",
                          "apply=%0b heavy=%0b epp=%0d fan=%0b"},
                         r.temperature, r.mode, r.throttled, r.recovery_count,
                         r.profile_apply, r.profile_heavy, r.epp_value, r.fan_kick);
    endfunction

    function automatic result_t outcome(
        input logic [TempW-1:0]  deg,
        input logic [ModeW-1:0]  m,
        input logic              thr,
        input logic [CountW-1:0] rc,
        input logic              apply,
        input logic              heavy,
        input logic [EppW-1:0]   epp,
        input logic              fan
    );
        return {deg, m, thr, rc, apply, heavy, epp, fan};
    endfunction

    function automatic stim_t tick_row(
        input logic [LoadW-1:0]   load,
        input logic [TccW-1:0]    tcc,
        input logic [OffsetW-1:0] off,
        input logic               ok
    );
        stim_t s;
        begin
            s = '0;
            s.tick = {load, tcc, off, ok};
            return s;
        end
    endfunction

    function automatic stim_t known_row(
        input logic [LoadW-1:0]   load,
        input logic [TccW-1:0]    tcc,
        input logic [OffsetW-1:0] off,
        input logic               ok,
        input result_t            want
    );
        stim_t s;
        begin
            s          = tick_row(load, tcc, off, ok);
            s.has_want = 1'b1;
            s.want     = want;
            return s;
        end
    endfunction

    // Temperature aimed at the current regime or right at a threshold
    function automatic int pick_temp();
        int hot_lo;
        int cool_hi;
        int deg;
        begin
            hot_lo  = (int'(lim_hot) > TARGET_MAX) ? TARGET_DEFAULT : int'(lim_hot);
            cool_hi = (lim_cool == '0) ? 10 : int'(lim_cool) - 1;
            if (cool_hi > TARGET_MAX)
                cool_hi = TARGET_MAX;
            if ($urandom_range(0, 3) == 0)
                deg = ($urandom_range(0, 1) ? int'(lim_hot) : int'(lim_cool))
                      - int'($urandom_range(0, 1));
            else if (run_hot)
                deg = $urandom_range(hot_lo, TARGET_MAX);
            else
                deg = $urandom_range(0, cool_hi);
            if (deg < 0)
                deg = 0;
            if (deg > TARGET_MAX)
                deg = TARGET_MAX;
            return deg;
        end
    endfunction

    // Mostly runs of hot/cool and heavy/relieved ticks, some raw noise
    function automatic stim_t random_tick();
        stim_t s;
        int    deg;
        int    tgt;
        int    thr;
        begin
            s = '0;
            if ($urandom_range(0, 9) == 0)
                run_hot = !run_hot;
            if ($urandom_range(0, 5) == 0)
                run_heavy = !run_heavy;
            if ($urandom_range(0, 7) == 0)
            begin
                s.tick = $urandom;
                return s;
            end

            thr = lim_load;
            if ($urandom_range(0, 15) == 0)
                s.tick.load_factor = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else if (run_heavy && thr > 0)
                s.tick.load_factor = 16'(($urandom_range(0, 3) == 0) ? thr - 1
                                         : int'($urandom_range(0, thr - 1)));
            else
                s.tick.load_factor = 16'(($urandom_range(0, 3) == 0) ? thr
                                         : int'($urandom_range(thr, 65535)));

            deg = pick_temp();
            tgt = $urandom_range((deg < TARGET_MIN) ? TARGET_MIN : deg, TARGET_MAX);
            s.tick.tcc_target     = 8'(tgt);
            s.tick.readout_offset = 7'(tgt - deg);
            s.tick.reading_valid  = ($urandom_range(0, 15) != 0);
            return s;
        end
    endfunction

    task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_TEMP_HIGH:      lim_hot      = val[TempW-1:0];
            CFG_TEMP_RECOVERY:  lim_cool     = val[TempW-1:0];
            CFG_RECOVERY_TICKS: lim_recover  = val[CountW-1:0];
            CFG_LOAD_THRESHOLD: lim_load     = val[LoadW-1:0];
            CFG_COOLDOWN_TICKS: lim_cooldown = val[CoolW-1:0];
            CFG_EPP_LOW:        epp_lo       = val[EppW-1:0];
            CFG_EPP_HEAVY:      epp_hv       = val[EppW-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_governor(
        input logic [CfgDataW-1:0] hot,
        input logic [CfgDataW-1:0] cool,
        input logic [CfgDataW-1:0] recover,
        input logic [CfgDataW-1:0] load,
        input logic [CfgDataW-1:0] cooldown,
        input logic [CfgDataW-1:0] e_lo,
        input logic [CfgDataW-1:0] e_hv
    );
        write_reg(CFG_TEMP_HIGH, hot);
        write_reg(CFG_TEMP_RECOVERY, cool);
        write_reg(CFG_RECOVERY_TICKS, recover);
        write_reg(CFG_LOAD_THRESHOLD, load);
        write_reg(CFG_COOLDOWN_TICKS, cooldown);
        write_reg(CFG_EPP_LOW, e_lo);
        write_reg(CFG_EPP_HEAVY, e_hv);
    endtask

    // Wait until every tick is in and every result is out
    task automatic drain();
        while (ticks_to_send.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int n_ticks, input bit squeeze);
        repeat (n_ticks) ticks_to_send.push_back(random_tick());
        if (squeeze)
            hold_pending = 1'b1;
        drain();
    endtask

    // Sender: bursts of ticks separated by random gaps
    always @(posedge clk)
    begin : sender
        stim_t   taken;
        result_t predicted;
        int      burst_left;
        int      gap_left;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                taken     = ticks_to_send.pop_front();
                predicted = govern_tick(taken.tick);
                pending_results.push_back(taken.has_want ? taken.want : predicted);
            end

            if (in_valid && in_stall)
            begin
                // payload held while stalled
            end
            else if (ticks_to_send.size() != 0 && gap_left == 0)
            begin
                in_valid       <= 1'b1;
                load_factor    <= ticks_to_send[0].tick.load_factor;
                tcc_target     <= ticks_to_send[0].tick.tcc_target;
                readout_offset <= ticks_to_send[0].tick.readout_offset;
                reading_valid  <= ticks_to_send[0].tick.reading_valid;
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 40);
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                               ($urandom_range(0, 7) == 0) ? $urandom_range(13, 30) :
                                                             $urandom_range(1, 12);
            end
            else
            begin
                in_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
        end
    end

    // Receiver: stall pattern picked at random from four styles, plus one long hold
    always @(posedge clk)
    begin : receiver
        stall_style_t style;
        int           style_left;
        int           hold_left;
        if (rst_n)
        begin
            if (style_left == 0)
            begin
                style      = stall_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(20, 80);
            end
            style_left--;
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (style)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : result_monitor
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {temperature, mode, throttled, recovery_count,
                   profile_apply, profile_heavy, epp_value, fan_kick};
            if (pending_results.size() == 0)
            begin
                bad_results++;
                if (bad_results <= MAX_REPORTS)
                    $display("unexpected result: %s", describe(got));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.temperature    !== want.temperature    ||
                    got.mode           !== want.mode           ||
                    got.throttled      !== want.throttled      ||
                    got.recovery_count !== want.recovery_count ||
                    got.profile_apply  !== want.profile_apply  ||
                    got.profile_heavy  !== want.profile_heavy  ||
                    got.epp_value      !== want.epp_value      ||
                    got.fan_kick       !== want.fan_kick)
                begin
                    bad_results++;
                    if (bad_results <= MAX_REPORTS)
                    begin
                        $display("mismatch expected: %s", describe(want));
                        $display("         actual:   %s", describe(got));
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("no transaction for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin : main
        int hot;
        int r;

        // Directed ticks under reset settings
        directed_rows[0]  = known_row(16'hFFFF, 8'd0, 7'd0, 1'b0,
                                      outcome(7'd0, MODE_LOW, 1'b0, 4'd0, 1'b0, 1'b0,
                                              8'd0, 1'b0));
        directed_rows[1]  = known_row(16'hFFFF, 8'd255, 7'd127, 1'b1,
                                      outcome(7'd0, MODE_LOW, 1'b0, 4'd0, 1'b0, 1'b0,
                                              8'd0, 1'b0));
        directed_rows[2]  = known_row(16'hFFFF, 8'd70, 7'd0, 1'b1,
                                      outcome(7'd70, MODE_LOW, 1'b0, 4'd0, 1'b0, 1'b0,
                                              8'd0, 1'b0));
        directed_rows[3]  = known_row(16'hFFFF, 8'd110, 7'd0, 1'b1,
                                      outcome(7'd110, MODE_LOW, 1'b1, 4'd0, 1'b1, 1'b0,
                                              8'd208, 1'b0));
        directed_rows[4]  = known_row(16'h0000, 8'd69, 7'd30, 1'b1,
                                      outcome(7'd70, MODE_LOW, 1'b1, 4'd1, 1'b0, 1'b0,
                                              8'd0, 1'b0));
        directed_rows[5]  = known_row(16'h0000, 8'd111, 7'd100, 1'b1,
                                      outcome(7'd0, MODE_LOW, 1'b1, 4'd2, 1'b0, 1'b0,
                                              8'd0, 1'b0));
        directed_rows[6]  = known_row(16'h0000, 8'd100, 7'd20, 1'b1,
                                      outcome(7'd80, MODE_LOW, 1'b1, 4'd0, 1'b0, 1'b0,
                                              8'd0, 1'b0));
        directed_rows[7]  = tick_row(16'h0000, 8'd80, 7'd10, 1'b1);
        directed_rows[8]  = tick_row(16'h0000, 8'd80, 7'd10, 1'b1);
        directed_rows[9]  = known_row(16'h0000, 8'd80, 7'd10, 1'b1,
                                      outcome(7'd70, MODE_HEAVY, 1'b0, 4'd0, 1'b1, 1'b1,
                                              8'd128, 1'b1));
        directed_rows[10] = tick_row(16'd1000, 8'd80, 7'd80, 1'b1);
        directed_rows[11] = tick_row(16'd999, 8'd80, 7'd0, 1'b1);
        directed_rows[12] = tick_row(16'd1000, 8'd80, 7'd5, 1'b1);
        directed_rows[13] = tick_row(16'hFFFF, 8'd75, 7'd1, 1'b1);
        directed_rows[14] = tick_row(16'hFFFF, 8'd75, 7'd1, 1'b1);
        directed_rows[15] = tick_row(16'hFFFF, 8'd75, 7'd1, 1'b1);
        directed_rows[16] = tick_row(16'hFFFF, 8'd75, 7'd1, 1'b1);
        directed_rows[17] = known_row(16'hFFFF, 8'd75, 7'd1, 1'b1,
                                      outcome(7'd74, MODE_LOW, 1'b0, 4'd0, 1'b1, 1'b0,
                                              8'd208, 1'b0));
        directed_rows[18] = tick_row(16'h0000, 8'd75, 7'd0, 1'b1);
        directed_rows[19] = known_row(16'h0000, 8'd85, 7'd0, 1'b1,
                                      outcome(7'd85, MODE_LOW, 1'b1, 4'd0, 1'b1, 1'b0,
                                              8'd208, 1'b0));
        directed_rows[20] = tick_row(16'h0000, 8'd74, 7'd0, 1'b1);
        directed_rows[21] = tick_row(16'h0000, 8'd75, 7'd0, 1'b1);
        directed_rows[22] = tick_row(16'hFFFF, 8'd70, 7'd70, 1'b1);
        directed_rows[23] = tick_row(16'hFFFF, 8'd200, 7'd127, 1'b0);
        directed_rows[24] = known_row(16'hFFFF, 8'h80, 7'd64, 1'b1,
                                      outcome(7'd36, MODE_LOW, 1'b0, 4'd0, 1'b0, 1'b0,
                                              8'd0, 1'b0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            ticks_to_send.push_back(directed_rows[i]);
        drain();

        // Reset settings, with a long output hold-off while ticks keep coming
        random_phase(200, 1'b1);

        // Clamp engages and releases in one tick: low apply then heavy apply
        program_governor(16'd0, 16'd127, 16'd0, 16'hFFFF, 16'd0, 16'd255, 16'd0);
        write_reg(CFG_SPARE, 16'hFFFF);
        random_phase(100, 1'b0);

        // Clamp never engages, load never heavy
        program_governor(16'd127, 16'd0, 16'd15, 16'd0, 16'd255, 16'd0, 16'd255);
        random_phase(100, 1'b0);

        // Recovery threshold above the engage threshold, single-tick recovery
        program_governor(16'd80, 16'd100, 16'd1, 16'd30000, 16'd2, 16'd17, 16'd240);
        random_phase(150, 1'b0);

        // Longest recovery, cooldown limit of zero
        program_governor(16'd90, 16'd60, 16'd15, 16'd5000, 16'd0, 16'd208, 16'd128);
        random_phase(150, 1'b0);

        // Raw write data, upper bits beyond each register set at random
        program_governor(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)));
        random_phase(140, 1'b0);

        // Random but sensible settings
        for (r = 0; r < 4; r++)
        begin
            hot = $urandom_range(60, 110);
            program_governor(16'(hot), 16'(hot - int'($urandom_range(0, 25))),
                             16'($urandom_range(0, 15)),
                             16'($urandom_range(1, 65535)), 16'($urandom_range(0, 12)),
                             16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)));
            random_phase(140, 1'b0);
        end

        if (bad_results == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
